FILE: hw/rtl/bwdp_pkg.sv
// Shared types, constants and helpers of the bf16 weight dot-product row engine.
// No dependencies; the front end, back end, multiplier, top level and testbench import this package.
package bwdp_pkg;

  // Field and register widths
  localparam int FP_W        = 32;
  localparam int BF_W        = 16;
  localparam int VEC_LEN_W   = 13;
  localparam int ROW_COUNT_W = 17;
  localparam int ROW_W       = 16;

  // Defaults and limits
  localparam int MAX_VEC_LEN_DEF = 4096;
  localparam int QUEUE_DEPTH     = 4;
  localparam logic [ROW_COUNT_W-1:0] ROWS_MAX = 17'd65536;

  // Request kinds on the action field
  localparam logic ACTION_LOAD   = 1'b0;
  localparam logic ACTION_WEIGHT = 1'b1;

  // Register index as decoded from paddr[2]
  localparam logic REG_VEC_LEN   = 1'b0;
  localparam logic REG_ROW_COUNT = 1'b1;

  // Canonical quiet NaN
  localparam logic [FP_W-1:0] FP_QNAN = 32'h7FC0_0000;

  // Per-weight tag carried down the datapath
  typedef struct packed {
    logic             last;
    logic [ROW_W-1:0] row;
  } tag_t;

  // Classified request held in the queue (address travels beside it)
  typedef struct packed {
    logic            is_load;
    tag_t            tag;
    logic [FP_W-1:0] data;
  } cmd_t;

  // Leading-zero count of a 48-bit word; 48 when the word is zero
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] cnt;
    cnt = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) begin
        cnt = 6'(47 - i);
      end
    end
    return cnt;
  endfunction

endpackage

FILE: hw/rtl/bwdp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bwdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/bwdp_queue.sv
// Short FIFO between the front classifier and the back datapath.
// Depends on nothing; width and depth come from the instantiating module.
module bwdp_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  assign data_o  = slot_q[rd_q];
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);

  // Flow control must never overrun or underrun the queue
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");

endmodule

FILE: hw/rtl/bwdp_fmul.sv
// Three-stage fp32 multiplier: mantissa product, normalise, round to nearest-even.
// Subnormals kept. Depends on bwdp_pkg.
module bwdp_fmul
  import bwdp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [FP_W-1:0] a_i,
  input  logic [FP_W-1:0] b_i,
  input  tag_t            tag_i,
  output logic            valid_o,
  output logic [FP_W-1:0] prod_o,
  output tag_t            tag_o
);

  // ---------------- stage M: unpack and multiply ----------------
  logic [7:0]  ea, eb, eea, eeb;
  logic [23:0] ma, mb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic        m_nan_d, m_inf_d, m_zero_d;

  always_comb begin
    ea     = a_i[30:23];
    eb     = b_i[30:23];
    eea    = (ea == 8'd0) ? 8'd1 : ea;
    eeb    = (eb == 8'd0) ? 8'd1 : eb;
    ma     = {(ea != 8'd0), a_i[22:0]};
    mb     = {(eb != 8'd0), b_i[22:0]};
    a_nan  = (ea == 8'hFF) && (a_i[22:0] != '0);
    b_nan  = (eb == 8'hFF) && (b_i[22:0] != '0);
    a_inf  = (ea == 8'hFF) && (a_i[22:0] == '0);
    b_inf  = (eb == 8'hFF) && (b_i[22:0] == '0);
    a_zero = (ea == 8'd0) && (a_i[22:0] == '0);
    b_zero = (eb == 8'd0) && (b_i[22:0] == '0);
    m_nan_d  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
    m_inf_d  = !m_nan_d && (a_inf || b_inf);
    m_zero_d = a_zero || b_zero;
  end

  logic              m_valid_q;
  logic [47:0]       m_p_q;
  logic signed [9:0] m_e_q;
  logic              m_sign_q, m_nan_q, m_inf_q, m_zero_q;
  tag_t              m_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en_i) begin
      m_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_p_q    <= ma * mb;
      m_e_q    <= $signed({2'b00, eea}) + $signed({2'b00, eeb}) - 10'sd126;
      m_sign_q <= a_i[31] ^ b_i[31];
      m_nan_q  <= m_nan_d;
      m_inf_q  <= m_inf_d;
      m_zero_q <= m_zero_d;
      m_tag_q  <= tag_i;
    end
  end

  // ---------------- stage N1: normalise left ----------------
  logic [5:0] lz;
  assign lz = lzc48(m_p_q);

  logic              n_valid_q;
  logic [47:0]       n_p_q;
  logic signed [9:0] n_e_q;
  logic              n_sign_q, n_nan_q, n_inf_q, n_zero_q;
  tag_t              n_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_valid_q <= 1'b0;
    end else if (en_i) begin
      n_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_p_q    <= m_p_q << lz;
      n_e_q    <= m_e_q - $signed({4'b0000, lz});
      n_sign_q <= m_sign_q;
      n_nan_q  <= m_nan_q;
      n_inf_q  <= m_inf_q;
      n_zero_q <= m_zero_q;
      n_tag_q  <= m_tag_q;
    end
  end

  // ---------------- stage N2: denormalise and round ----------------
  logic [9:0]  s_full;
  logic [5:0]  s;
  logic [7:0]  fld;
  logic [97:0] ext;
  logic [23:0] mnt;
  logic        g, st, rnd;
  logic [31:0] pk;
  logic [FP_W-1:0] res;

  always_comb begin
    s_full = 10'd0;
    if (n_e_q > 10'sd0) begin
      s   = 6'd0;
      fld = n_e_q[7:0];
    end else begin
      s_full = 10'd1 - n_e_q;
      s      = (s_full > 10'd50) ? 6'd50 : s_full[5:0];
      fld    = 8'd0;
    end
    ext = {n_p_q, 50'd0} >> s;
    mnt = ext[97:74];
    g   = ext[73];
    st  = |ext[72:0];
    rnd = g && (st || mnt[0]);
    pk  = {1'b0, fld, mnt[22:0]} + {31'd0, rnd};
    if (n_nan_q) begin
      res = FP_QNAN;
    end else if (n_inf_q) begin
      res = {n_sign_q, 8'hFF, 23'd0};
    end else if (n_zero_q) begin
      res = {n_sign_q, 31'd0};
    end else if (n_e_q >= 10'sd255) begin
      res = {n_sign_q, 8'hFF, 23'd0};
    end else begin
      res = {n_sign_q, pk[30:0]};
    end
  end

  logic            o_valid_q;
  logic [FP_W-1:0] o_prod_q;
  tag_t            o_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (en_i) begin
      o_valid_q <= n_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o_prod_q <= res;
      o_tag_q  <= n_tag_q;
    end
  end

  assign valid_o = o_valid_q;
  assign prod_o  = o_prod_q;
  assign tag_o   = o_tag_q;

endmodule

FILE: hw/rtl/bwdp_front.sv
// Front end: accepts requests, keeps load pointer, column and row counters,
// and hands classified requests to the queue. Depends on bwdp_pkg.
module bwdp_front
  import bwdp_pkg::*;
#(
  parameter int MAX_VEC_LEN = MAX_VEC_LEN_DEF,
  localparam int AW = (MAX_VEC_LEN > 1) ? $clog2(MAX_VEC_LEN) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   action_i,
  input  logic [FP_W-1:0]        activation_bits_i,
  input  logic [BF_W-1:0]        weight_bits_i,
  input  logic [VEC_LEN_W-1:0]   vec_len_i,
  input  logic [ROW_COUNT_W-1:0] row_count_i,
  input  logic                   full_i,
  output logic                   push_o,
  output cmd_t                   cmd_o,
  output logic [AW-1:0]          addr_o
);

  localparam int LW = AW + 1;
  localparam int CW = (VEC_LEN_W > LW) ? VEC_LEN_W : LW;

  logic [AW-1:0]    ptr_q, ptr_d, col_q, col_d, lp;
  logic [ROW_W-1:0] row_q, row_d;
  logic [CW-1:0]    vl_ext;
  logic [LW-1:0]    eff_len, lp_nxt, col_nxt;
  logic [ROW_COUNT_W-1:0] rows, row_nxt;
  logic             accept, is_load, last;

  // Effective length and row count
  always_comb begin
    vl_ext = CW'(vec_len_i);
    if (vl_ext == '0) begin
      eff_len = LW'(1);
    end else if (vl_ext > CW'(MAX_VEC_LEN)) begin
      eff_len = LW'(MAX_VEC_LEN);
    end else begin
      eff_len = vl_ext[LW-1:0];
    end
    if (row_count_i == '0) begin
      rows = ROW_COUNT_W'(1);
    end else if (row_count_i > ROWS_MAX) begin
      rows = ROWS_MAX;
    end else begin
      rows = row_count_i;
    end
  end

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;
  assign is_load    = (action_i == ACTION_LOAD);

  // Counter stepping
  always_comb begin
    lp      = ({1'b0, ptr_q} >= eff_len) ? '0 : ptr_q;
    lp_nxt  = {1'b0, lp} + 1'b1;
    col_nxt = {1'b0, col_q} + 1'b1;
    last    = (col_nxt >= eff_len);
    row_nxt = {1'b0, row_q} + 1'b1;
    ptr_d   = ptr_q;
    col_d   = col_q;
    row_d   = row_q;
    if (accept) begin
      if (is_load) begin
        ptr_d = (lp_nxt >= eff_len) ? '0 : lp_nxt[AW-1:0];
      end else begin
        col_d = last ? '0 : col_nxt[AW-1:0];
        if (last) begin
          row_d = (row_nxt >= rows) ? '0 : row_nxt[ROW_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      col_q <= '0;
      row_q <= '0;
    end else begin
      ptr_q <= ptr_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Classified request
  always_comb begin
    push_o           = accept;
    cmd_o.is_load    = is_load;
    cmd_o.tag.last   = last;
    cmd_o.tag.row    = row_q;
    cmd_o.data       = is_load ? activation_bits_i : {{(FP_W-BF_W){1'b0}}, weight_bits_i};
    addr_o           = is_load ? lp : col_q;
  end

endmodule

FILE: hw/rtl/bwdp_back.sv
// Back end: activation store, multiplier pipeline, fp32 accumulate into a registered running sum
// and result register. Depends on bwdp_pkg, bwdp_ram and bwdp_fmul.
module bwdp_back
  import bwdp_pkg::*;
#(
  parameter int MAX_VEC_LEN = MAX_VEC_LEN_DEF,
  localparam int AW = (MAX_VEC_LEN > 1) ? $clog2(MAX_VEC_LEN) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  logic [AW-1:0]    addr_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [FP_W-1:0]  result_bits_o,
  output logic [ROW_W-1:0] row_index_o,
  output logic             was_nonfinite_o
);

  logic en, pop;

  // The whole back end freezes only while a result waits and is stalled
  assign en    = !out_valid_o || !out_stall_i;
  assign pop   = en && !empty_i;
  assign pop_o = pop;

  // Activation store
  logic [FP_W-1:0] act;

  bwdp_ram #(
    .WIDTH (FP_W),
    .DEPTH (MAX_VEC_LEN)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (pop && cmd_i.is_load),
    .waddr_i (addr_i),
    .wdata_i (cmd_i.data),
    .re_i    (en),
    .raddr_i (addr_i),
    .rdata_o (act)
  );

  // Weight beside the store read
  logic            s1_valid_q;
  logic [BF_W-1:0] s1_w_q;
  tag_t            s1_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= pop && !cmd_i.is_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_w_q   <= cmd_i.data[BF_W-1:0];
      s1_tag_q <= cmd_i.tag;
    end
  end

  // Multiplier
  logic            p_valid;
  logic [FP_W-1:0] prod;
  tag_t            p_tag;

  bwdp_fmul u_fmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_valid_q),
    .a_i     (act),
    .b_i     ({s1_w_q, {(FP_W-BF_W){1'b0}}}),
    .tag_i   (s1_tag_q),
    .valid_o (p_valid),
    .prod_o  (prod),
    .tag_o   (p_tag)
  );

  // fp32 add of running sum and product, round to nearest-even
  logic [FP_W-1:0] sum_q, sum_d, add_res, ax, ay;
  logic [7:0]  ex_f, ey_f, exe, eye, dexp, fld, lim;
  logic [23:0] mx, my, mnt;
  logic [4:0]  sh, shamt;
  logic [58:0] t;
  logic [26:0] xal, yal, zn;
  logic [27:0] z;
  logic [5:0]  lz;
  logic [8:0]  en9;
  logic [31:0] pk;
  logic        sub, g, st, rnd, zsign;
  logic        sa_nan, sb_nan, sa_inf, sb_inf;

  always_comb begin
    // Specials
    sa_nan = (sum_q[30:23] == 8'hFF) && (sum_q[22:0] != '0);
    sb_nan = (prod[30:23] == 8'hFF) && (prod[22:0] != '0);
    sa_inf = (sum_q[30:23] == 8'hFF) && (sum_q[22:0] == '0);
    sb_inf = (prod[30:23] == 8'hFF) && (prod[22:0] == '0);
    // Larger magnitude first
    if (prod[30:0] > sum_q[30:0]) begin
      ax = prod;
      ay = sum_q;
    end else begin
      ax = sum_q;
      ay = prod;
    end
    ex_f = ax[30:23];
    ey_f = ay[30:23];
    exe  = (ex_f == 8'd0) ? 8'd1 : ex_f;
    eye  = (ey_f == 8'd0) ? 8'd1 : ey_f;
    mx   = {(ex_f != 8'd0), ax[22:0]};
    my   = {(ey_f != 8'd0), ay[22:0]};
    // Align with guard, round and sticky
    dexp = exe - eye;
    sh   = (dexp > 8'd31) ? 5'd31 : dexp[4:0];
    t    = {my, 3'b000, 32'd0} >> sh;
    yal  = t[58:32] | {26'd0, |t[31:0]};
    xal  = {mx, 3'b000};
    sub  = ax[31] ^ ay[31];
    z    = sub ? ({1'b0, xal} - {1'b0, yal}) : ({1'b0, xal} + {1'b0, yal});
    // Normalise
    lz    = lzc48({z[26:0], 21'h1F_FFFF});
    lim   = exe - 8'd1;
    shamt = 5'd0;
    if (z[27]) begin
      zn  = {z[27:2], z[1] | z[0]};
      en9 = {1'b0, exe} + 9'd1;
    end else begin
      shamt = ({2'b00, lz} < lim) ? lz[4:0] : lim[4:0];
      zn    = z[26:0] << shamt;
      en9   = {1'b0, exe} - {4'b0000, shamt};
    end
    fld = zn[26] ? en9[7:0] : 8'd0;
    mnt = zn[26:3];
    g   = zn[2];
    st  = zn[1] | zn[0];
    rnd = g && (st || mnt[0]);
    pk  = {1'b0, fld, mnt[22:0]} + {31'd0, rnd};
    zsign = sub ? 1'b0 : ax[31];
    if (sa_nan || sb_nan || (sa_inf && sb_inf && (sum_q[31] != prod[31]))) begin
      add_res = FP_QNAN;
    end else if (sa_inf) begin
      add_res = {sum_q[31], 8'hFF, 23'd0};
    end else if (sb_inf) begin
      add_res = {prod[31], 8'hFF, 23'd0};
    end else if (z == '0) begin
      add_res = {zsign, 31'd0};
    end else if (zn[26] && (en9 >= 9'd255)) begin
      add_res = {ax[31], 8'hFF, 23'd0};
    end else begin
      add_res = {ax[31], pk[30:0]};
    end
  end

  // Running sum and result register
  logic             fire;
  logic             out_valid_q, out_valid_d;
  logic [FP_W-1:0]  res_q;
  logic [ROW_W-1:0] row_q;
  logic             nf_q;
  logic             nonfinite;

  assign fire      = en && p_valid;
  assign nonfinite = (add_res[30:23] == 8'hFF);

  always_comb begin
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    if (fire) begin
      sum_d = p_tag.last ? '0 : add_res;
    end
    if (en) begin
      out_valid_d = fire && p_tag.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && p_tag.last) begin
      res_q <= nonfinite ? '0 : add_res;
      row_q <= p_tag.row;
      nf_q  <= nonfinite;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_bits_o   = res_q;
  assign row_index_o     = row_q;
  assign was_nonfinite_o = nf_q;

  // A closing weight always presents a result and restarts the sum at +0
  a_row_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && p_tag.last) |=> out_valid_q) else $error("row close without result");
  a_sum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && p_tag.last) |=> (sum_q == '0)) else $error("sum not cleared at row end");
  a_sum_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(sum_q)) else $error("sum moved while frozen");

endmodule

FILE: hw/rtl/bf16_weight_dot_product_rows_top.sv
// Top level of the bf16 weight by fp32 activation row dot-product engine.
// Depends on bwdp_pkg, bwdp_front, bwdp_queue and bwdp_back.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------------
//   in      | input     | in_valid_i / in_stall_o   | action_i, activation_bits_i, weight_bits_i
//   out     | output    | out_valid_o / out_stall_i | result_bits_o, row_index_o, was_nonfinite_o
//   cfg     | input     | psel, penable / pready | paddr, pwrite, pwdata, prdata
//
// One request is accepted per cycle while in_stall_o is low; the fp32 accumulate is combinational.
// After its last weight is accepted, a row result passes through the queue, the store read,
// the three multiplier stages and the accumulate into the result register.
// Reset clears counters, sum and valids; the activation store is not cleared.
// An output stall freezes the back end; the four-entry queue then fills before in_stall_o rises.
module bf16_weight_dot_product_rows_top
  import bwdp_pkg::*;
#(
  parameter int MAX_VEC_LEN = MAX_VEC_LEN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             action_i,
  input  logic [FP_W-1:0]  activation_bits_i,
  input  logic [BF_W-1:0]  weight_bits_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [FP_W-1:0]  result_bits_o,
  output logic [ROW_W-1:0] row_index_o,
  output logic             was_nonfinite_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = (MAX_VEC_LEN > 1) ? $clog2(MAX_VEC_LEN) : 1;
  localparam int QW = $bits(cmd_t) + AW;

  // Configuration registers
  logic [VEC_LEN_W-1:0]   vec_len_q;
  logic [ROW_COUNT_W-1:0] row_count_q;
  logic                   cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_len_q   <= VEC_LEN_W'(1);
      row_count_q <= ROW_COUNT_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_VEC_LEN) begin
        vec_len_q <= pwdata[VEC_LEN_W-1:0];
      end else begin
        row_count_q <= pwdata[ROW_COUNT_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_ROW_COUNT) ? 32'(row_count_q) : 32'(vec_len_q);

  // Front end
  logic          push, pop, full, empty;
  cmd_t          f_cmd, q_cmd;
  logic [AW-1:0] f_addr, q_addr;

  bwdp_front #(
    .MAX_VEC_LEN (MAX_VEC_LEN)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .activation_bits_i (activation_bits_i),
    .weight_bits_i     (weight_bits_i),
    .vec_len_i         (vec_len_q),
    .row_count_i       (row_count_q),
    .full_i            (full),
    .push_o            (push),
    .cmd_o             (f_cmd),
    .addr_o            (f_addr)
  );

  // Request queue
  logic [QW-1:0] q_head;

  bwdp_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_cmd, f_addr}),
    .pop_i   (pop),
    .data_o  (q_head),
    .full_o  (full),
    .empty_o (empty)
  );

  assign q_cmd  = q_head[QW-1:AW];
  assign q_addr = q_head[AW-1:0];

  // Back end
  bwdp_back #(
    .MAX_VEC_LEN (MAX_VEC_LEN)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (q_cmd),
    .addr_i          (q_addr),
    .empty_i         (empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_bits_o   (result_bits_o),
    .row_index_o     (row_index_o),
    .was_nonfinite_o (was_nonfinite_o)
  );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the bf16 weight by fp32 activation row dot-product engine.
// Depends on bwdp_pkg and bf16_weight_dot_product_rows_top; it keeps its own row-sum predictor.
module tb;
  import bwdp_pkg::*;

  localparam int  STORE_DEPTH = 4096;
  localparam int  DRAIN_GAP   = 16;
  localparam int  CYCLE_LIMIT = 600000;
  localparam logic [2:0] ADDR_VEC_LEN   = 3'd0;
  localparam logic [2:0] ADDR_ROW_COUNT = 3'd4;

  typedef struct packed {
    logic [FP_W-1:0]  sum;
    logic [ROW_W-1:0] row;
    logic             nonfinite;
  } row_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             action_i = ACTION_LOAD;
  logic [FP_W-1:0]  activation_bits_i = '0;
  logic [BF_W-1:0]  weight_bits_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [FP_W-1:0]  result_bits_o;
  logic [ROW_W-1:0] row_index_o;
  logic             was_nonfinite_o;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  bf16_weight_dot_product_rows_top uut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [FP_W-1:0]    act_mem [STORE_DEPTH];
  bit                 act_written [STORE_DEPTH];
  int unsigned        load_ptr, column, row_ctr;
  logic [FP_W-1:0]    row_sum;
  logic [VEC_LEN_W-1:0]   vec_len_reg;
  logic [ROW_COUNT_W-1:0] row_count_reg;
  row_result_t        pending_rows [$];

  bit gaps_on, stalls_on;
  int fails, requests_sent, rows_seen, nonfinite_seen;
  int unsigned cycles;

  // fp32 bits to real, subnormals normalised into the double format
  function automatic real fp32_to_real(logic [31:0] b);
    logic [23:0] m;
    int          k;
    m = {1'b0, b[22:0]};
    k = 0;
    if (b[30:23] == 8'hFF) return $bitstoreal({b[31], 11'h7FF, b[22:0], 29'b0});
    if (b[30:23] != 8'h00)
      return $bitstoreal({b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'b0});
    if (m == 0) return $bitstoreal({b[31], 63'b0});
    while (!m[23]) begin
      m = m << 1;
      k++;
    end
    return $bitstoreal({b[31], 11'(1023 - 126 - k), m[22:0], 29'b0});
  endfunction

  // Real to fp32 bits, round to nearest even, subnormals kept
  function automatic logic [31:0] real_to_fp32(real r);
    logic [63:0] d, sig, kept, rem, half;
    int          eb, sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF)
      return (d[51:0] != 0) ? {d[63], 8'hFF, 23'h400000} : {d[63], 8'hFF, 23'h0};
    if (d[62:52] == 11'h000) return {d[63], 31'b0};
    eb  = int'(d[62:52]) - 1023 + 127;
    sig = {11'b0, 1'b1, d[51:0]};
    sh  = (eb >= 1) ? 29 : 29 + 1 - eb;
    if (sh > 60) return {d[63], 31'b0};
    kept = sig >> sh;
    half = 64'd1 << (sh - 1);
    rem  = sig & ((64'd1 << sh) - 1);
    if (rem > half || (rem == half && kept[0])) kept++;
    if (eb < 1) return {d[63], kept[30:0]};
    if (kept[24]) begin
      kept = kept >> 1;
      eb++;
    end
    if (eb >= 255) return {d[63], 8'hFF, 23'h0};
    return {d[63], 8'(eb), kept[22:0]};
  endfunction

  function automatic int unsigned active_len();
    if (vec_len_reg == 0) return 1;
    if (vec_len_reg > STORE_DEPTH) return STORE_DEPTH;
    return vec_len_reg;
  endfunction

  // Update the predictor with one accepted request, queue a row sum if one closes
  task automatic predict_request(logic act, logic [31:0] a, logic [15:0] w);
    int unsigned len, rows;
    logic [31:0] prod;
    row_result_t r;
    len = active_len();
    rows = (row_count_reg == 0) ? 1 : (row_count_reg > ROWS_MAX ? ROWS_MAX : row_count_reg);
    if (act == ACTION_LOAD) begin
      if (load_ptr >= len) load_ptr = 0;
      act_mem[load_ptr] = a;
      act_written[load_ptr] = 1'b1;
      load_ptr++;
      if (load_ptr >= len) load_ptr = 0;
      return;
    end
    prod = real_to_fp32(fp32_to_real(act_mem[column]) * fp32_to_real({w, 16'h0}));
    row_sum = real_to_fp32(fp32_to_real(row_sum) + fp32_to_real(prod));
    column++;
    if (column < len) return;
    r.nonfinite = (row_sum[30:23] == 8'hFF);
    r.sum = r.nonfinite ? '0 : row_sum;
    r.row = row_ctr[ROW_W-1:0];
    pending_rows = {pending_rows, r};
    row_sum = '0;
    column = 0;
    row_ctr++;
    if (row_ctr >= rows) row_ctr = 0;
  endtask

  // Send one request; a weight whose activation was never loaded becomes a load
  task automatic send_request(logic act, logic [31:0] a, logic [15:0] w);
    logic a_act;
    a_act = (act == ACTION_WEIGHT && !act_written[column]) ? ACTION_LOAD : act;
    while (gaps_on && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= a_act;
    activation_bits_i <= a;
    weight_bits_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_request(a_act, a, w);
    requests_sent++;
  endtask

  // Wait until every queued row sum has come back, then let the pipeline settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_VEC_LEN) vec_len_reg = data[VEC_LEN_W-1:0];
    else row_count_reg = data[ROW_COUNT_W-1:0];
  endtask

  task automatic set_shape(logic [31:0] len, logic [31:0] rows);
    wait_drained();
    write_reg(ADDR_VEC_LEN, len);
    write_reg(ADDR_ROW_COUNT, rows);
  endtask

  // Random fp32 with a bias towards finite, moderate magnitudes
  function automatic logic [31:0] rand_fp32();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return {1'($urandom), 8'($urandom_range(100, 154)), 23'($urandom)};
    if (pick < 80) return $urandom;
    if (pick < 90) return {1'($urandom), 8'($urandom_range(0, 12)), 23'($urandom)};
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return 32'h7F80_0000;
      3:       return FP_QNAN;
      4:       return 32'h7F7F_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    row_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rows_seen++;
      if (was_nonfinite_o) nonfinite_seen++;
      if (pending_rows.size() == 0) begin
        $error("row sum with nothing expected: row %0d", row_index_o);
        fails++;
      end else begin
        e = pending_rows.pop_front();
        if (result_bits_o !== e.sum) begin
          $error("result_bits expected %h got %h", e.sum, result_bits_o);
          fails++;
        end
        if (row_index_o !== e.row) begin
          $error("row_index expected %0d got %0d", e.row, row_index_o);
          fails++;
        end
        if (was_nonfinite_o !== e.nonfinite) begin
          $error("was_nonfinite expected %b got %b", e.nonfinite, was_nonfinite_o);
          fails++;
        end
      end
    end
  end

  // Receiver stalls
  always @(posedge clk_i) out_stall_i <= stalls_on && ($urandom_range(0, 99) < 20);

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Default shape: one activation, one weight per row; corner values of both formats
  task automatic test_corner_values();
    logic [15:0] wlist [10];
    wlist = '{16'h3F80, 16'hBF80, 16'h7F80, 16'hFF80, 16'h7FC0, 16'h0001, 16'h7F7F,
              16'h0000, 16'h8000, 16'hFFFF};
    send_request(ACTION_LOAD, 32'h3F80_0000, 16'hFFFF);
    foreach (wlist[i]) send_request(ACTION_WEIGHT, 32'hFFFF_FFFF, wlist[i]);
    // half the smallest subnormal ties to zero
    send_request(ACTION_LOAD, 32'h0000_0001, 16'h0000);
    send_request(ACTION_WEIGHT, 32'h0, 16'h3F00);
    // overflow to infinity
    send_request(ACTION_LOAD, 32'h7F7F_FFFF, 16'h0);
    send_request(ACTION_WEIGHT, 32'h0, 16'h4000);
    // NaN activation
    send_request(ACTION_LOAD, 32'hFFFF_FFFF, 16'h0);
    send_request(ACTION_WEIGHT, 32'h0, 16'h0000);
    send_request(ACTION_LOAD, 32'h8000_0000, 16'h0);
    send_request(ACTION_WEIGHT, 32'h0, 16'h8000);
  endtask

  // Out-of-range register values; a long row at the largest length, left open
  task automatic test_register_limits();
    set_shape(32'd0, 32'd0);
    send_request(ACTION_LOAD, 32'h4040_0000, 16'h0);
    repeat (3) send_request(ACTION_WEIGHT, 32'h0, 16'h4000);
    set_shape(32'd4096, 32'd65536);
    for (int i = 0; i < 300; i++) send_request(ACTION_LOAD, rand_fp32(), 16'($urandom));
    for (int i = 0; i < 250; i++) send_request(ACTION_WEIGHT, $urandom, 16'(rand_fp32() >> 16));
    set_shape(32'd8191, 32'h1FFFF);
    for (int i = 0; i < 40; i++) send_request(ACTION_WEIGHT, $urandom, 16'(rand_fp32() >> 16));
  endtask

  // Length and row count shrunk while a row and the load pointer are part way through
  task automatic test_midstream_shrink();
    set_shape(32'd8, 32'd4);
    for (int i = 0; i < 8; i++) send_request(ACTION_LOAD, rand_fp32(), 16'h0);
    repeat (13) send_request(ACTION_WEIGHT, 32'h0, 16'(rand_fp32() >> 16));
    for (int i = 0; i < 5; i++) send_request(ACTION_LOAD, rand_fp32(), 16'h0);
    set_shape(32'd3, 32'd1);
    send_request(ACTION_LOAD, rand_fp32(), 16'h0);
    send_request(ACTION_WEIGHT, 32'h0, 16'(rand_fp32() >> 16));
    repeat (4) send_request(ACTION_WEIGHT, 32'h0, 16'(rand_fp32() >> 16));
  endtask

  // Random shapes: mostly whole vectors and rows, some loose mixes
  task automatic test_random_rows(int target);
    int start, len;
    start = requests_sent;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    while (requests_sent - start < target) begin
      if (requests_sent - start > 300) begin
        gaps_on = 1'b1;
        stalls_on = 1'b1;
      end
      set_shape($urandom_range(0, 99) < 90 ? $urandom_range(1, 12) : $urandom_range(13, 64),
                $urandom_range(1, 6));
      len = active_len();
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(0, 99) < 75) begin
          if ($urandom_range(0, 1)) begin
            for (int i = 0; i < len; i++) send_request(ACTION_LOAD, rand_fp32(), 16'($urandom));
          end
          repeat ($urandom_range(1, 4) * len)
            send_request(ACTION_WEIGHT, $urandom, 16'(rand_fp32() >> 16));
        end else begin
          repeat ($urandom_range(5, 30))
            send_request(1'($urandom), rand_fp32(), 16'(rand_fp32() >> 16));
        end
        // sender holds off until the block has caught up
        if ($urandom_range(0, 9) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    vec_len_reg = 1;
    row_count_reg = 1;
    row_sum = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_values();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    test_register_limits();
    test_midstream_shrink();
    test_random_rows(1200);
    wait_drained();
    $display("Sent %0d requests; checked %0d row sums, %0d of them non-finite.",
             requests_sent, rows_seen, nonfinite_seen);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
